// ===== rtl/lbps_pkg.sv =====
// shared types, constants and decode helpers for the led blink pattern sequencer
package lbps_pkg;

  // table geometry
  localparam int unsigned PatternSteps = 64;
  localparam int unsigned StepIdxW     = $clog2(PatternSteps);
  localparam int unsigned DurationBits = 16;
  localparam int unsigned CodeW        = 3;

  // stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  // led codes as the step table stores them
  localparam logic [CodeW-1:0] LedOff        = 3'd0;
  localparam logic [CodeW-1:0] LedRedBlink   = 3'd1;
  localparam logic [CodeW-1:0] LedRed        = 3'd2;
  localparam logic [CodeW-1:0] LedGreenBlink = 3'd3;
  localparam logic [CodeW-1:0] LedGreen      = 3'd4;
  localparam logic [CodeW-1:0] LedAmberBlink = 3'd5;
  localparam logic [CodeW-1:0] LedAmber      = 3'd6;
  localparam logic [CodeW-1:0] LedIgnored    = 3'd7;

  // highest code that changes the shown pattern
  localparam logic [CodeW-1:0] CodeMax = LedAmber;

  // request kinds carried on the slave tuser
  typedef enum logic [InUserW-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_e;

  // one stored step
  typedef struct packed {
    logic [CodeW-1:0]        code;
    logic [DurationBits-1:0] duration;
    logic [StepIdxW-1:0]     next;
    logic                    is_final;
  } step_t;

  localparam int unsigned StepW = $bits(step_t);

  // pin levels for a shown code
  typedef struct packed {
    logic red;
    logic green;
    logic blink;
  } pins_t;

  function automatic pins_t decode_pins(logic [CodeW-1:0] code);
    pins_t p;
    p.red   = (code == LedRedBlink) || (code == LedRed) ||
              (code == LedAmberBlink) || (code == LedAmber);
    p.green = (code == LedGreenBlink) || (code == LedGreen) ||
              (code == LedAmberBlink) || (code == LedAmber);
    p.blink = (code == LedRedBlink) || (code == LedGreenBlink) || (code == LedAmberBlink);
    return p;
  endfunction

endpackage

// ===== rtl/lbps_ram.sv =====
// generic simple dual port ram with one write port and a registered read port
module lbps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/led_blink_pattern_sequencer.sv =====
// top level of the led blink pattern sequencer: step table, countdown and result register
//
// Plays LED blink patterns from a 64-entry step table held in a synchronous RAM.
// Slave stream: tuser carries the request kind (tick, start, stop, load); tdata
// carries the start index and the step fields for a load. Every request yields
// exactly one result on the master stream with the shown code, the pin levels,
// the playing flag and the step position after that request.
// A request is taken into the update stage at acceptance, when its table read
// also happens; the update then writes the result register as that stage
// advances, which the master side can stall.
// Throughput: one request per cycle while the master side takes results; the
// table read address of a tick is forwarded from the update of the request
// ahead of it, so no bubbles are needed between dependent ticks.
// Loads write the table at acceptance; a running pattern sees the new step the
// next time it reads that entry. Table contents are undefined after reset and
// must be loaded before they are played.
// Reset clears position, countdown, playing flag and shown code (LED off) and
// empties the pipeline. When the master stalls, one result waits in the output
// register, one more request can be accepted into the update stage, and then
// s_axis_tready drops until the result is taken.
module led_blink_pattern_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // start_index[5:0], entry_index[11:6], entry_led_code[14:12],
  // entry_duration[30:15], entry_next[36:31], entry_final[37], zero[39:38]
  input  logic [lbps_pkg::InDataW-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [lbps_pkg::InUserW-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // led_code[2:0], red_on[3], green_on[4], hard_blink[5], playing[6],
  // step_position[12:7], zero[15:13]
  output logic [lbps_pkg::OutDataW-1:0] m_axis_tdata
);

  import lbps_pkg::*;

  // request fields
  mode_e                   in_mode;
  logic [StepIdxW-1:0]     in_start;
  logic [StepIdxW-1:0]     in_entry_idx;
  step_t                   in_entry;
  logic                    in_fire;

  // update stage
  logic                    s1_valid_q, s1_valid_d;
  mode_e                   s1_mode_q;
  logic [StepIdxW-1:0]     s1_start_q;
  logic                    s1_adv;
  step_t                   rd_step;

  // play state
  logic [StepIdxW-1:0]     cur_step_q, cur_step_d;
  logic [DurationBits-1:0] ticks_q, ticks_d, ticks_dec;
  logic                    running_q, running_d;
  logic [CodeW-1:0]        shown_q, shown_d;
  logic                    do_apply;
  logic [StepIdxW-1:0]     apply_base;

  // result register
  logic                    m_valid_q, m_valid_d;
  logic [OutDataW-1:0]     m_data_q, m_data_d;
  pins_t                   pins;

  // unpack the request
  assign in_mode               = mode_e'(s_axis_tuser);
  assign in_start              = s_axis_tdata[5:0];
  assign in_entry_idx          = s_axis_tdata[11:6];
  assign in_entry.code         = s_axis_tdata[14:12];
  assign in_entry.duration     = s_axis_tdata[30:15];
  assign in_entry.next         = s_axis_tdata[36:31];
  assign in_entry.is_final     = s_axis_tdata[37];

  // handshakes
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // step table, read address of a tick forwarded from the update in flight
  lbps_ram #(
    .Width (StepW),
    .Depth (PatternSteps)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire && (in_mode == MODE_LOAD)),
    .wr_addr_i (in_entry_idx),
    .wr_data_i (in_entry),
    .rd_en_i   (in_fire && ((in_mode == MODE_TICK) || (in_mode == MODE_START))),
    .rd_addr_i ((in_mode == MODE_START) ? in_start : cur_step_d),
    .rd_data_o (rd_step)
  );

  // play state update
  always_comb begin
    cur_step_d = cur_step_q;
    ticks_d    = ticks_q;
    running_d  = running_q;
    shown_d    = shown_q;
    do_apply   = 1'b0;
    apply_base = cur_step_q;
    ticks_dec  = ticks_q - 1'b1;
    if (s1_adv) begin
      case (s1_mode_q)
        MODE_TICK: begin
          if (running_q) begin
            if (ticks_dec == '0) begin
              do_apply = 1'b1;
            end else begin
              ticks_d = ticks_dec;
            end
          end
        end
        MODE_START: begin
          do_apply   = 1'b1;
          apply_base = s1_start_q;
        end
        MODE_STOP: begin
          running_d = 1'b0;
          ticks_d   = '0;
          shown_d   = '0;
        end
        default: begin
        end
      endcase
    end
    // show the read step unless its code is ignored, and arm its countdown when timed, else stop playing
    if (do_apply) begin
      cur_step_d = apply_base;
      if (rd_step.code <= CodeMax) begin
        shown_d = rd_step.code;
      end
      if (!rd_step.is_final && (rd_step.duration != '0)) begin
        ticks_d    = rd_step.duration;
        running_d  = 1'b1;
        cur_step_d = rd_step.next;
      end else begin
        ticks_d   = '0;
        running_d = 1'b0;
      end
    end
  end

  // result word and valid
  always_comb begin
    pins        = decode_pins(shown_d);
    m_data_d    = '0;
    m_data_d[2:0]  = shown_d;
    m_data_d[3]    = pins.red;
    m_data_d[4]    = pins.green;
    m_data_d[5]    = pins.blink;
    m_data_d[6]    = running_d;
    m_data_d[12:7] = cur_step_d;
    m_valid_d   = m_valid_q && !m_axis_tready;
    if (s1_adv) begin
      m_valid_d = 1'b1;
    end
    s1_valid_d = s1_valid_q && !s1_adv;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end
  end

  // control and play state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      cur_step_q <= '0;
      ticks_q    <= '0;
      running_q  <= 1'b0;
      shown_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
      cur_step_q <= cur_step_d;
      ticks_q    <= ticks_d;
      running_q  <= running_d;
      shown_q    <= shown_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= in_mode;
      s1_start_q <= in_start;
    end
    if (s1_adv) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
